>>> src/vtg_pkg.sv
// Shared types, constants and saturation helpers for the vertex tangent generator.
// No dependencies; vtg_div, vtg_sqrt and the top level import it.
package vtg_pkg;

  // vertex store geometry
  localparam int unsigned VIDX_W   = 10;
  localparam int unsigned NUM_VERT = 1 << VIDX_W;

  // divider geometry: dividend carries 16 fraction bits on top of a 64-bit magnitude
  localparam int unsigned DIVD_W    = 80;
  localparam int unsigned DIVS_W    = 64;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DSTEP_W   = $clog2(DIV_STEPS);

  // square root: 64-bit radicand, 32-bit root, one bit per step
  localparam int unsigned SQ_STEPS = 32;
  localparam int unsigned SSTEP_W  = $clog2(SQ_STEPS);

  localparam logic signed [31:0] OUT_MAX = 32'sd131071;
  localparam logic signed [31:0] OUT_MIN = -32'sd131072;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_TRI   = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_UV_PRESENT = 2'd0,
    CFG_DET_EPS    = 2'd1,
    CFG_LEN_EPS    = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE,
    ST_TRD0, ST_TRD1, ST_TRD2, ST_TRD3, ST_DELTA,
    ST_MUL1, ST_MUL2, ST_MSUB, ST_TDIV, ST_TDIVW,
    ST_ARD, ST_AWR,
    ST_RRD, ST_RLAT, ST_RDIV, ST_RDIVW,
    ST_SQMUL, ST_SQACC, ST_SQRT, ST_SQRTW,
    ST_NDIV, ST_NDIVW, ST_OUT
  } state_e;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] tu;
    logic signed [31:0] tv;
  } vertex_t;

  typedef struct packed {
    logic signed [47:0] sx;
    logic signed [47:0] sy;
    logic signed [47:0] sz;
    logic [15:0]        cnt;
  } accum_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
    logic              neg;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  function automatic logic signed [17:0] clamp18(input logic signed [31:0] v);
    if (v > OUT_MAX) begin
      return OUT_MAX[17:0];
    end
    if (v < OUT_MIN) begin
      return OUT_MIN[17:0];
    end
    return v[17:0];
  endfunction

  function automatic logic [63:0] mag65(input logic signed [64:0] v);
    logic signed [64:0] t;
    t = v[64] ? -v : v;
    return t[63:0];
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    logic signed [48:0] t;
    t = v[47] ? -49'(v) : 49'(v);
    return t[47:0];
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    logic signed [32:0] t;
    t = v[31] ? -33'(v) : 33'(v);
    return t[31:0];
  endfunction

endpackage

>>> src/vtg_ram.sv
// Generic simple dual-port synchronous RAM with a registered read.
// No dependencies.
module vtg_ram #(
  parameter int unsigned WIDTH = 160,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/vtg_div.sv
// Iterative restoring divider, one quotient bit per cycle, signed saturated Q16.16 result.
// Depends on vtg_pkg.
module vtg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vtg_pkg::div_req_t  req_i,
  output vtg_pkg::div_rsp_t  rsp_o
);
  import vtg_pkg::*;

  logic               busy_q, fin_q, done_q;
  logic [DSTEP_W-1:0] cnt_q;
  logic [DIVS_W-1:0]  rem_q, dvs_q;
  logic [31:0]        dvd_q, quo_q;
  logic               neg_q, ovf_q;
  logic signed [31:0] res_q;

  logic [DIVS_W:0]    trial;
  logic               ge;
  logic [31:0]        limit, qsat;

  // one trial subtraction per step
  always_comb begin
    trial = {rem_q, dvd_q[31]};
    ge    = trial >= {1'b0, dvs_q};
    limit = neg_q ? 32'h80000000 : 32'h7fffffff;
    qsat  = (ovf_q || (quo_q > limit)) ? limit : quo_q;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DSTEP_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      ovf_q <= DIVS_W'(req_i.dividend[DIVD_W-1:32]) >= req_i.divisor;
      rem_q <= DIVS_W'(req_i.dividend[DIVD_W-1:32]);
      dvd_q <= req_i.dividend[31:0];
      dvs_q <= req_i.divisor;
      neg_q <= req_i.neg;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? DIVS_W'(trial - {1'b0, dvs_q}) : trial[DIVS_W-1:0];
      quo_q <= {quo_q[30:0], ge};
      dvd_q <= {dvd_q[30:0], 1'b0};
    end
    if (fin_q) begin
      res_q <= neg_q ? (32'd0 - qsat) : qsat;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = res_q;

endmodule

>>> src/vtg_sqrt.sv
// Iterative integer square root, one root bit per cycle over a 64-bit radicand.
// Depends on vtg_pkg.
module vtg_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import vtg_pkg::*;

  logic               busy_q, done_q;
  logic [SSTEP_W-1:0] cnt_q;
  logic [63:0]        val_q;
  logic [33:0]        rem_q;
  logic [31:0]        root_q;

  logic [35:0]        r, trial;
  logic               ge;

  // bring down two radicand bits, test root*4+1
  always_comb begin
    r     = {rem_q, val_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    ge    = r >= trial;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == SSTEP_W'(SQ_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? 34'(r - trial) : r[33:0];
      root_q <= {root_q[30:0], ge};
      val_q  <= {val_q[61:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> src/vertex_tangent_generator.sv
// Vertex tangent generator top level: sequencer, shared multiplier, two state memories.
// Depends on vtg_pkg, vtg_ram, vtg_div and vtg_sqrt.
//
// One word is handled at a time. After reset all 1024 accumulator entries are swept clean,
// one entry a cycle, before the first word is taken. A vertex write is stored as the word is
// taken. A triangle reads its three corners, runs eight 32x32 products through one multiplier
// and three divisions through the shared 32-step divider, then read-modify-writes the three
// accumulators; when the determinant counts as zero the remaining products and the divisions
// are skipped, and without texture coordinates only the accumulator updates run. A read runs
// three averaging divisions, three squares, a 32-step square root and, when the length
// exceeds its epsilon, three normalizing divisions, then waits, if need be, for the output
// register to free up. A finished result waits in the output register while the next word is
// already being taken.
module vertex_tangent_generator (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [15:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               kind_i,
  input  logic [vtg_pkg::VIDX_W-1:0] vertex_a_i,
  input  logic [vtg_pkg::VIDX_W-1:0] vertex_b_i,
  input  logic [vtg_pkg::VIDX_W-1:0] vertex_c_i,
  input  logic signed [31:0]       pos_x_in_i,
  input  logic signed [31:0]       pos_y_in_i,
  input  logic signed [31:0]       pos_z_in_i,
  input  logic signed [31:0]       tex_u_in_i,
  input  logic signed [31:0]       tex_v_in_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [17:0]       tangent_x_o,
  output logic signed [17:0]       tangent_y_o,
  output logic signed [17:0]       tangent_z_o,
  output logic                     was_normalized_o
);
  import vtg_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic        uv_present_q;
  logic [15:0] det_eps_q, len_eps_q;

  // captured word and working registers
  logic [VIDX_W-1:0]  clr_cnt_q;
  logic [VIDX_W-1:0]  a_q, b_q, c_q;
  vertex_t            va_q, vb_q, vc_q;
  logic signed [31:0] du10_q, dv10_q, du20_q, dv20_q;
  logic signed [31:0] e1_q [3];
  logic signed [31:0] e2_q [3];
  logic signed [63:0] prod_q, p1_q;
  logic signed [64:0] det_q, num_q;
  logic [1:0]         pi_q, k_q, corner_q;
  logic signed [31:0] t_q [3];
  logic signed [31:0] avg_q [3];
  accum_t             acc_q;
  logic [63:0]        sq_q;
  logic [31:0]        len_q;
  logic               norm_q;

  // output register
  logic               out_valid_q;
  logic signed [17:0] tx_q, ty_q, tz_q;
  logic               wn_q;

  logic               in_fire, out_load;
  logic [1:0]         cidx;
  logic [VIDX_W-1:0]  corner_idx;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [64:0] diff;
  logic               det_small;
  accum_t             acc_new;
  logic signed [47:0] sum_k;

  // memory ports
  logic              vram_we;
  logic [VIDX_W-1:0] vram_raddr;
  vertex_t           vram_wdata, vram_rdata;
  logic              aram_we;
  logic [VIDX_W-1:0] aram_waddr, aram_raddr;
  accum_t            aram_wdata, aram_rdata;

  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_root;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // corner and component selects
  assign cidx = pi_q - 2'd1;
  always_comb begin
    case (corner_q)
      2'd0:    corner_idx = a_q;
      2'd1:    corner_idx = b_q;
      default: corner_idx = c_q;
    endcase
  end

  always_comb begin
    case (k_q)
      2'd0:    sum_k = acc_q.sx;
      2'd1:    sum_k = acc_q.sy;
      default: sum_k = acc_q.sz;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = avg_q[k_q];
    mul_b = avg_q[k_q];
    if (state_q == ST_MUL1) begin
      mul_a = (pi_q == 2'd0) ? du10_q : dv20_q;
      mul_b = (pi_q == 2'd0) ? dv20_q : e1_q[cidx];
    end else if (state_q == ST_MUL2) begin
      mul_a = (pi_q == 2'd0) ? du20_q : dv10_q;
      mul_b = (pi_q == 2'd0) ? dv10_q : e2_q[cidx];
    end
  end
  assign mul_p = mul_a * mul_b;

  assign diff      = 65'(p1_q) - 65'(prod_q);
  assign det_small = !uv_present_q || (mag65(diff) <= (64'(det_eps_q) << 16));

  // saturating accumulate of the face tangent into one corner
  always_comb begin
    acc_new.sx  = sat48(49'(aram_rdata.sx) + 49'(t_q[0]));
    acc_new.sy  = sat48(49'(aram_rdata.sy) + 49'(t_q[1]));
    acc_new.sz  = sat48(49'(aram_rdata.sz) + 49'(t_q[2]));
    acc_new.cnt = (aram_rdata.cnt == 16'hffff) ? aram_rdata.cnt : aram_rdata.cnt + 16'd1;
  end

  // memory port muxing
  always_comb begin
    vram_we            = in_fire && (kind_e'(kind_i) == KIND_WRITE);
    vram_wdata.px      = pos_x_in_i;
    vram_wdata.py      = pos_y_in_i;
    vram_wdata.pz      = pos_z_in_i;
    vram_wdata.tu      = tex_u_in_i;
    vram_wdata.tv      = tex_v_in_i;
    case (state_q)
      ST_TRD1: vram_raddr = b_q;
      ST_TRD2: vram_raddr = c_q;
      default: vram_raddr = a_q;
    endcase

    aram_we    = 1'b0;
    aram_waddr = vertex_a_i;
    aram_wdata = '0;
    aram_raddr = (state_q == ST_ARD) ? corner_idx : a_q;
    if (state_q == ST_CLEAR) begin
      aram_we    = 1'b1;
      aram_waddr = clr_cnt_q;
    end else if (vram_we) begin
      aram_we = 1'b1;
    end else if (state_q == ST_AWR) begin
      aram_we    = 1'b1;
      aram_waddr = corner_idx;
      aram_wdata = acc_new;
    end
  end

  // divider and square root requests
  always_comb begin
    div_req = '0;
    case (state_q)
      ST_TDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = {mag65(num_q), 16'd0};
        div_req.divisor  = mag65(det_q);
        div_req.neg      = num_q[64] ^ det_q[64];
      end
      ST_RDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(mag48(sum_k));
        div_req.divisor  = (acc_q.cnt == 16'd0) ? DIVS_W'(1) : DIVS_W'(acc_q.cnt);
        div_req.neg      = sum_k[47];
      end
      ST_NDIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'({mag32(avg_q[k_q]), 16'd0});
        div_req.divisor  = DIVS_W'(len_q);
        div_req.neg      = avg_q[k_q][31];
      end
      default: ;
    endcase
  end
  assign sqrt_start = (state_q == ST_SQRT);

  // next state
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == VIDX_W'(NUM_VERT - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_fire) begin
          case (kind_e'(kind_i))
            KIND_TRI:  state_d = uv_present_q ? ST_TRD0 : ST_ARD;
            KIND_READ: state_d = ST_RRD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_TRD0:  state_d = ST_TRD1;
      ST_TRD1:  state_d = ST_TRD2;
      ST_TRD2:  state_d = ST_TRD3;
      ST_TRD3:  state_d = ST_DELTA;
      ST_DELTA: state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MSUB;
      ST_MSUB: begin
        if (pi_q != 2'd0) begin
          state_d = ST_TDIV;
        end else begin
          state_d = det_small ? ST_ARD : ST_MUL1;
        end
      end
      ST_TDIV:  state_d = ST_TDIVW;
      ST_TDIVW: if (div_rsp.done) state_d = (pi_q == 2'd3) ? ST_ARD : ST_MUL1;
      ST_ARD:   state_d = ST_AWR;
      ST_AWR:   state_d = (corner_q == 2'd2) ? ST_IDLE : ST_ARD;
      ST_RRD:   state_d = ST_RLAT;
      ST_RLAT:  state_d = ST_RDIV;
      ST_RDIV:  state_d = ST_RDIVW;
      ST_RDIVW: if (div_rsp.done) state_d = (k_q == 2'd2) ? ST_SQMUL : ST_RDIV;
      ST_SQMUL: state_d = ST_SQACC;
      ST_SQACC: state_d = (k_q == 2'd2) ? ST_SQRT : ST_SQMUL;
      ST_SQRT:  state_d = ST_SQRTW;
      ST_SQRTW: begin
        if (sqrt_done) begin
          state_d = (sqrt_root > 32'(len_eps_q)) ? ST_NDIV : ST_OUT;
        end
      end
      ST_NDIV:  state_d = ST_NDIVW;
      ST_NDIVW: if (div_rsp.done) state_d = (k_q == 2'd2) ? ST_OUT : ST_NDIV;
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      uv_present_q <= 1'b1;
      det_eps_q    <= 16'd1;
      len_eps_q    <= 16'd1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_UV_PRESENT: uv_present_q <= cfg_data_i[0];
          CFG_DET_EPS:    det_eps_q    <= cfg_data_i;
          CFG_LEN_EPS:    len_eps_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    p1_q   <= prod_q;
    if (in_fire) begin
      a_q <= vertex_a_i;
      b_q <= vertex_b_i;
      c_q <= vertex_c_i;
      corner_q <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        t_q[i] <= '0;
      end
    end
    case (state_q)
      ST_TRD1: va_q <= vram_rdata;
      ST_TRD2: vb_q <= vram_rdata;
      ST_TRD3: vc_q <= vram_rdata;
      ST_DELTA: begin
        du10_q  <= sat32(33'(vb_q.tu) - 33'(va_q.tu));
        dv10_q  <= sat32(33'(vb_q.tv) - 33'(va_q.tv));
        du20_q  <= sat32(33'(vc_q.tu) - 33'(va_q.tu));
        dv20_q  <= sat32(33'(vc_q.tv) - 33'(va_q.tv));
        e1_q[0] <= sat32(33'(vb_q.px) - 33'(va_q.px));
        e1_q[1] <= sat32(33'(vb_q.py) - 33'(va_q.py));
        e1_q[2] <= sat32(33'(vb_q.pz) - 33'(va_q.pz));
        e2_q[0] <= sat32(33'(vc_q.px) - 33'(va_q.px));
        e2_q[1] <= sat32(33'(vc_q.py) - 33'(va_q.py));
        e2_q[2] <= sat32(33'(vc_q.pz) - 33'(va_q.pz));
        pi_q    <= 2'd0;
      end
      ST_MSUB: begin
        if (pi_q == 2'd0) begin
          det_q <= diff;
          pi_q  <= 2'd1;
        end else begin
          num_q <= diff;
        end
      end
      ST_TDIVW: begin
        if (div_rsp.done) begin
          t_q[cidx] <= div_rsp.quot;
          pi_q      <= pi_q + 2'd1;
        end
      end
      ST_AWR: corner_q <= corner_q + 2'd1;
      ST_RLAT: begin
        acc_q <= aram_rdata;
        k_q   <= 2'd0;
      end
      ST_RDIVW: begin
        if (div_rsp.done) begin
          avg_q[k_q] <= div_rsp.quot;
          k_q        <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
          sq_q       <= '0;
        end
      end
      ST_SQACC: begin
        sq_q <= sq_q + 64'(prod_q);
        k_q  <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
      end
      ST_SQRTW: begin
        if (sqrt_done) begin
          len_q  <= sqrt_root;
          norm_q <= sqrt_root > 32'(len_eps_q);
          k_q    <= 2'd0;
        end
      end
      ST_NDIVW: begin
        if (div_rsp.done) begin
          avg_q[k_q] <= div_rsp.quot;
          k_q        <= k_q + 2'd1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      tx_q <= clamp18(avg_q[0]);
      ty_q <= clamp18(avg_q[1]);
      tz_q <= clamp18(avg_q[2]);
      wn_q <= norm_q;
    end
  end

  // vertex position and texture coordinate store
  vtg_ram #(
    .WIDTH ($bits(vertex_t)),
    .DEPTH (NUM_VERT)
  ) u_vert_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vertex_a_i),
    .wdata_i (vram_wdata),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  // tangent sums and face counts
  vtg_ram #(
    .WIDTH ($bits(accum_t)),
    .DEPTH (NUM_VERT)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (aram_we),
    .waddr_i (aram_waddr),
    .wdata_i (aram_wdata),
    .raddr_i (aram_raddr),
    .rdata_o (aram_rdata)
  );

  vtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  vtg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sq_q),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign out_valid_o      = out_valid_q;
  assign tangent_x_o      = tx_q;
  assign tangent_y_o      = ty_q;
  assign tangent_z_o      = tz_q;
  assign was_normalized_o = wn_q;

endmodule
